### rtl/bir_pkg.sv
package bir_pkg;

  // default sizes of the source store and the target image
  localparam int MAX_SRC_WIDTH    = 256;
  localparam int MAX_SRC_HEIGHT   = 256;
  localparam int MAX_DST_SIZE     = 256;
  localparam int WEIGHT_FRAC_BITS = 14;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SEL = 3'd4;

  // request opcodes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // kernel codes
  localparam logic KERNEL_MITCHELL = 1'b0;
  localparam logic KERNEL_HERMITE  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] src_x;
    logic [7:0] src_y;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic [7:0] dst_x;
    logic [7:0] dst_y;
  } bir_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } bir_out_t;

endpackage

### rtl/bir_ram.sv
module bir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/bicubic_image_resampler.sv
// Bicubic resampler: opcode 0 transfers write one RGBA8 source pixel into the pixel store
// (one per cycle while no request holds the input stalled, no result); opcode 1 transfers
// request one target pixel, resampled from a clamped 4x4 source neighborhood with a
// Mitchell-Netravali or Hermite kernel, and return one result. A request keeps the input
// stalled until its result is loaded into the result register; with the Hermite kernel,
// where fewer taps carry weight, the weight phase is shorter. A channel that needs no
// normalizing division skips the divider, and a result that waits on out_stall holds the
// block for as long as it waits. The block uses one bit-serial divider (source position
// and final normalization) and one shared multiplier that walks the sixteen taps and four
// channels, with the taps read from the single read port of the pixel store.
module bicubic_image_resampler #(
  parameter int MAX_SRC_WIDTH    = bir_pkg::MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT   = bir_pkg::MAX_SRC_HEIGHT,
  parameter int MAX_DST_SIZE     = bir_pkg::MAX_DST_SIZE,
  parameter int WEIGHT_FRAC_BITS = bir_pkg::WEIGHT_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bir_pkg::bir_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bir_pkg::bir_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int F     = WEIGHT_FRAC_BITS;
  localparam int MAXS  = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int MAXA  = (MAXS > MAX_DST_SIZE) ? MAXS : MAX_DST_SIZE;
  localparam int SZW   = $clog2(MAXA + 1);
  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADW   = $clog2(DEPTH);
  localparam int KAX   = $clog2(MAXS + 1) + 16;
  localparam int IXW   = KAX - 8;
  localparam int WW    = F + 2;
  localparam int PW    = 2 * F + 4;
  localparam int SW    = 2 * F + 12;
  localparam int AW    = (PW > 27) ? PW : 27;
  localparam int BW0   = (F + 2 > 11) ? F + 2 : 11;
  localparam int BW    = (BW0 > $clog2(MAXS + 1) + 1) ? BW0 : $clog2(MAXS + 1) + 1;
  localparam int MW    = AW + BW;
  localparam int NW0   = 2 * F + 14;
  localparam int NW1   = KAX + $clog2(MAX_DST_SIZE + 1) + 2;
  localparam int NW    = (NW0 > NW1) ? NW0 : NW1;
  localparam int QW    = (KAX > F + 1) ? KAX : F + 1;
  localparam int CTW   = $clog2(QW + 1);
  localparam int HW    = 33 + F;
  // reciprocal of 9 for the Mitchell weight scaling, exact for quotients below 2^(F+8)
  localparam int RK    = F + 11;
  localparam int RPW   = 2 * F + 20;
  localparam logic [RK:0] RECIP9 = (RK+1)'(((longint'(1) << RK) + longint'(8)) / longint'(9));

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_AX_MUL = 5'd1;
  localparam logic [4:0] S_AX_LD  = 5'd2;
  localparam logic [4:0] S_AX_DIV = 5'd3;
  localparam logic [4:0] S_W_A    = 5'd4;
  localparam logic [4:0] S_W_M1   = 5'd5;
  localparam logic [4:0] S_W_M2   = 5'd6;
  localparam logic [4:0] S_W_N    = 5'd7;
  localparam logic [4:0] S_W_NEXT = 5'd9;
  localparam logic [4:0] S_T_RD   = 5'd10;
  localparam logic [4:0] S_T_W    = 5'd11;
  localparam logic [4:0] S_T_C    = 5'd12;
  localparam logic [4:0] S_T_A    = 5'd13;
  localparam logic [4:0] S_F_CHK  = 5'd14;
  localparam logic [4:0] S_F_DIV  = 5'd15;
  localparam logic [4:0] S_F_NEXT = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  // divider job kinds
  localparam logic [1:0] DK_AXIS   = 2'd0;
  localparam logic [1:0] DK_FINAL  = 2'd2;

  // configuration registers
  logic [8:0] src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic       kernel_r;

  // sequencer and datapath registers
  logic [4:0]             state_r, state_nxt;
  logic                   ax_r, ax_nxt;
  logic [1:0]             tap_r, tap_nxt;
  logic [1:0]             ti_r, ti_nxt;
  logic [1:0]             tj_r, tj_nxt;
  logic [1:0]             ch_r, ch_nxt;
  logic [7:0]             dx_r, dy_r;
  logic [7:0]             frac_r;
  logic [IXW-1:0]         bx_r, by_r;
  logic [9:0]             a_r;
  logic signed [WW-1:0]   wx_r [4];
  logic signed [WW-1:0]   wy_r [4];
  logic signed [PW-1:0]   w_r;
  logic [31:0]            px_r;
  logic signed [SW-1:0]   sum_r [4];
  logic signed [SW-1:0]   total_r;
  logic [7:0]             res_r [4];
  logic signed [MW-1:0]   prod_r;
  logic                   out_valid_r, out_valid_nxt;
  bir_pkg::bir_out_t      out_data_r;

  // divider registers
  logic [NW-1:0]          rem_r, dsh_r;
  logic [QW-1:0]          quot_r;
  logic [CTW-1:0]         dcnt_r;

  // clamped sizes
  logic [SZW-1:0] sw, sh, dw, dh;

  always_comb begin
    sw = (src_width_r == 9'd0) ? SZW'(1) :
         (int'(src_width_r) > MAX_SRC_WIDTH) ? SZW'(MAX_SRC_WIDTH) : SZW'(src_width_r);
    sh = (src_height_r == 9'd0) ? SZW'(1) :
         (int'(src_height_r) > MAX_SRC_HEIGHT) ? SZW'(MAX_SRC_HEIGHT) : SZW'(src_height_r);
    dw = (dst_width_r == 9'd0) ? SZW'(1) :
         (int'(dst_width_r) > MAX_DST_SIZE) ? SZW'(MAX_DST_SIZE) : SZW'(dst_width_r);
    dh = (dst_height_r == 9'd0) ? SZW'(1) :
         (int'(dst_height_r) > MAX_DST_SIZE) ? SZW'(MAX_DST_SIZE) : SZW'(dst_height_r);
  end

  // handshake
  logic in_xfer, out_xfer, out_free;
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pixel store
  logic              ram_we;
  logic [ADW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;
  logic              wr_in_range;

  assign wr_in_range = (int'(in_data.src_x) < MAX_SRC_WIDTH) &&
                       (int'(in_data.src_y) < MAX_SRC_HEIGHT);
  assign ram_we    = in_xfer && (in_data.opcode == bir_pkg::OP_WRITE) && wr_in_range;
  assign ram_waddr = ADW'(YW'(in_data.src_y) * MAX_SRC_WIDTH) + ADW'(XW'(in_data.src_x));
  assign ram_wdata = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};

  bir_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per-axis selections
  logic [7:0]     d_sel;
  logic [SZW-1:0] sz_sel, dsz_sel;
  assign d_sel   = ax_r ? dy_r : dx_r;
  assign sz_sel  = ax_r ? sh : sw;
  assign dsz_sel = ax_r ? dh : dw;

  // kernel polynomial coefficients for the current distance
  logic               hermite, zero_w;
  logic signed [15:0] a_s, tcoef;
  logic signed [23:0] ccoef;
  logic signed [32:0] kcoef;

  always_comb begin
    hermite = (kernel_r == bir_pkg::KERNEL_HERMITE);
    a_s     = $signed({6'b0, a_r});
    zero_w  = hermite ? (a_r >= 10'd256) : (a_r >= 10'd512);
    if (hermite) begin
      tcoef = (a_s <<< 1) - 16'sd768;
      ccoef = 24'sd0;
      kcoef = 33'sd16777216;
    end else if (a_r < 10'd256) begin
      tcoef = 16'sd21 * a_s - 16'sd9216;
      ccoef = 24'sd0;
      kcoef = 33'sd268435456;
    end else begin
      tcoef = 16'sd9216 - 16'sd7 * a_s;
      ccoef = -24'sd3932160;
      kcoef = 33'sd536870912;
    end
  end

  // weight numerator, magnitude and scaling
  logic signed [32:0] n_val, n_abs;
  logic               n_neg;
  logic [HW-1:0]      m_shift, herm_sum, mitch_sum;
  logic [F:0]         herm_mag, mitch_mag;
  logic [F+7:0]       mitch_q;
  logic [RPW-1:0]     mitch_prod;

  always_comb begin
    n_val      = kcoef + $signed(prod_r[32:0]);
    n_neg      = n_val[32];
    n_abs      = n_neg ? -n_val : n_val;
    m_shift    = HW'($unsigned(n_abs)) << F;
    herm_sum   = m_shift + (HW'(1) << 23);
    mitch_sum  = m_shift + (HW'(9) << 24);
    herm_mag   = herm_sum[24 +: F+1];
    mitch_q    = mitch_sum[25 +: F+8];
    // divide by 9 through the reciprocal
    mitch_prod = RPW'(mitch_q) * RPW'(RECIP9);
    mitch_mag  = mitch_prod[RK +: F+1];
  end

  // tap coordinates with edge clamp
  logic signed [IXW+1:0] cx, cy;
  logic [XW-1:0]         xx;
  logic [YW-1:0]         yy;

  always_comb begin
    cx = $signed({2'b00, bx_r}) + $signed({{IXW{1'b0}}, ti_r}) - $signed((IXW+2)'(1));
    cy = $signed({2'b00, by_r}) + $signed({{IXW{1'b0}}, tj_r}) - $signed((IXW+2)'(1));
    if (cx < 0) begin
      xx = '0;
    end else if (cx >= $signed((IXW+2)'(sw))) begin
      xx = XW'(sw - SZW'(1));
    end else begin
      xx = XW'(cx);
    end
    if (cy < 0) begin
      yy = '0;
    end else if (cy >= $signed((IXW+2)'(sh))) begin
      yy = YW'(sh - SZW'(1));
    end else begin
      yy = YW'(cy);
    end
  end

  assign ram_raddr = ADW'(yy * MAX_SRC_WIDTH) + ADW'(xx);

  // final channel values
  logic signed [SW-1:0] sum_sel;
  logic                 s_pos, t_pos, f_sat;
  logic [NW-1:0]        f_num, f_den;
  logic [SW-1:0]        rnd_sum;
  logic [SW-2*F-1:0]    rnd_val;
  logic [7:0]           nonorm_val;

  always_comb begin
    sum_sel    = sum_r[ch_r];
    s_pos      = (sum_sel > 0);
    t_pos      = (total_r > 0);
    f_num      = (NW'($unsigned(sum_sel)) << 1) + NW'($unsigned(total_r));
    f_den      = NW'($unsigned(total_r)) << 1;
    f_sat      = (f_num >= (f_den << 8));
    rnd_sum    = $unsigned(sum_sel) + (SW'(1) << (2 * F - 1));
    rnd_val    = rnd_sum[SW-1:2*F];
    nonorm_val = (rnd_val > (SW-2*F)'(255)) ? 8'hFF : rnd_val[7:0];
  end

  // shared multiplier operands
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [MW-1:0] mul_p;
  logic [7:0]           px_byte;

  assign px_byte = px_r[8*ch_r +: 8];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_AX_MUL: begin
        mul_a = AW'({1'b0, d_sel, 1'b1});
        mul_b = BW'(sz_sel);
      end
      S_W_M1: begin
        mul_a = AW'(tcoef);
        mul_b = BW'({1'b0, a_r});
      end
      S_W_M2: begin
        mul_a = $signed(prod_r[AW-1:0]) + AW'(ccoef);
        mul_b = BW'({1'b0, a_r});
      end
      S_T_RD: begin
        mul_a = AW'(wx_r[ti_r]);
        mul_b = BW'(wy_r[tj_r]);
      end
      S_T_C: begin
        mul_a = AW'(w_r);
        mul_b = BW'({1'b0, px_byte});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider job setup and weight store
  logic                 div_start;
  logic [1:0]           div_kind;
  logic [NW-1:0]        div_n, div_d, dsh_init;
  logic [CTW-1:0]       div_k;
  logic                 w_we;
  logic [F:0]           w_mag;
  logic                 w_neg;
  logic signed [WW-1:0] w_val;
  logic                 div_done;

  assign div_done = (dcnt_r == '0);

  always_comb begin
    div_start = 1'b0;
    div_kind  = DK_AXIS;
    div_n     = '0;
    div_d     = '0;
    w_we      = 1'b0;
    w_mag     = '0;
    w_neg     = 1'b0;
    unique case (state_r)
      S_AX_LD: begin
        div_start = 1'b1;
        div_kind  = DK_AXIS;
        div_n     = NW'($unsigned(prod_r)) << 8;
        div_d     = NW'(dsz_sel) << 1;
      end
      S_W_M1: begin
        w_we = zero_w;
      end
      S_W_N: begin
        w_we  = 1'b1;
        w_mag = hermite ? herm_mag : mitch_mag;
        w_neg = n_neg;
      end
      S_F_CHK: begin
        if (s_pos && t_pos && !f_sat) begin
          div_start = 1'b1;
          div_kind  = DK_FINAL;
          div_n     = f_num;
          div_d     = f_den;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
    w_val = w_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
  end

  always_comb begin
    dsh_init = '0;
    div_k    = '0;
    unique case (div_kind)
      DK_AXIS: begin
        dsh_init = div_d << (KAX - 1);
        div_k    = CTW'(KAX);
      end
      DK_FINAL: begin
        dsh_init = div_d << 7;
        div_k    = CTW'(8);
      end
      default: begin
        dsh_init = '0;
        div_k    = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    tap_nxt   = tap_r;
    ti_nxt    = ti_r;
    tj_nxt    = tj_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_data.opcode == bir_pkg::OP_REQUEST)) begin
          ax_nxt    = 1'b0;
          state_nxt = S_AX_MUL;
        end
      end
      S_AX_MUL: state_nxt = S_AX_LD;
      S_AX_LD:  state_nxt = S_AX_DIV;
      S_AX_DIV: begin
        if (div_done) begin
          tap_nxt   = 2'd0;
          state_nxt = S_W_A;
        end
      end
      S_W_A:  state_nxt = S_W_M1;
      S_W_M1: state_nxt = zero_w ? S_W_NEXT : S_W_M2;
      S_W_M2: state_nxt = S_W_N;
      S_W_N:  state_nxt = S_W_NEXT;
      S_W_NEXT: begin
        if (tap_r == 2'd3) begin
          if (!ax_r) begin
            ax_nxt    = 1'b1;
            state_nxt = S_AX_MUL;
          end else begin
            ti_nxt    = 2'd0;
            tj_nxt    = 2'd0;
            state_nxt = S_T_RD;
          end
        end else begin
          tap_nxt   = tap_r + 2'd1;
          state_nxt = S_W_A;
        end
      end
      S_T_RD: state_nxt = S_T_W;
      S_T_W: begin
        ch_nxt    = 2'd0;
        state_nxt = S_T_C;
      end
      S_T_C: state_nxt = S_T_A;
      S_T_A: begin
        if (ch_r == 2'd3) begin
          if (ti_r == 2'd3) begin
            ti_nxt = 2'd0;
            if (tj_r == 2'd3) begin
              ch_nxt    = 2'd0;
              state_nxt = S_F_CHK;
            end else begin
              tj_nxt    = tj_r + 2'd1;
              state_nxt = S_T_RD;
            end
          end else begin
            ti_nxt    = ti_r + 2'd1;
            state_nxt = S_T_RD;
          end
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_T_C;
        end
      end
      S_F_CHK: state_nxt = div_start ? S_F_DIV : S_F_NEXT;
      S_F_DIV: begin
        if (div_done) begin
          state_nxt = S_F_NEXT;
        end
      end
      S_F_NEXT: begin
        if (ch_r == 2'd3) begin
          state_nxt = S_OUT;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_F_CHK;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register valid
  always_comb begin
    if ((state_r == S_OUT) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 1'b0;
      tap_r       <= 2'd0;
      ti_r        <= 2'd0;
      tj_r        <= 2'd0;
      ch_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      tap_r       <= tap_nxt;
      ti_r        <= ti_nxt;
      tj_r        <= tj_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 9'd16;
      src_height_r <= 9'd16;
      dst_width_r  <= 9'd16;
      dst_height_r <= 9'd16;
      kernel_r     <= bir_pkg::KERNEL_MITCHELL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bir_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        bir_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data;
        bir_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_data;
        bir_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_data;
        bir_pkg::REG_KERNEL_SEL: kernel_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // bit-serial restoring divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (div_start) begin
      dcnt_r <= div_k;
    end else if (!div_done) begin
      dcnt_r <= dcnt_r - CTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      rem_r  <= div_n;
      dsh_r  <= dsh_init;
      quot_r <= '0;
    end else if (!div_done) begin
      if (rem_r >= dsh_r) begin
        rem_r  <= rem_r - dsh_r;
        quot_r <= {quot_r[QW-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;

    // request capture
    if (in_xfer) begin
      dx_r <= in_data.dst_x;
      dy_r <= in_data.dst_y;
    end

    // source position split into base and fraction
    if ((state_r == S_AX_DIV) && div_done) begin
      frac_r <= quot_r[7:0];
      if (ax_r) begin
        by_r <= quot_r[KAX-1:8];
      end else begin
        bx_r <= quot_r[KAX-1:8];
      end
    end

    // tap distance in 1/256 units
    if (state_r == S_W_A) begin
      case (tap_r)
        2'd0:    a_r <= 10'd256 + {2'b00, frac_r};
        2'd1:    a_r <= {2'b00, frac_r};
        2'd2:    a_r <= 10'd256 - {2'b00, frac_r};
        default: a_r <= 10'd512 - {2'b00, frac_r};
      endcase
    end

    // weight store
    if (w_we) begin
      if (ax_r) begin
        wy_r[tap_r] <= w_val;
      end else begin
        wx_r[tap_r] <= w_val;
      end
    end

    // accumulation over taps and channels
    if ((state_r == S_W_NEXT) && (tap_r == 2'd3) && ax_r) begin
      for (int c = 0; c < 4; c++) begin
        sum_r[c] <= '0;
      end
      total_r <= '0;
    end
    if (state_r == S_T_W) begin
      w_r     <= prod_r[PW-1:0];
      total_r <= total_r + $signed(prod_r[SW-1:0]);
      px_r    <= ram_rdata;
    end
    if (state_r == S_T_A) begin
      sum_r[ch_r] <= sum_r[ch_r] + $signed(prod_r[SW-1:0]);
    end

    // channel results
    if (state_r == S_F_CHK) begin
      if (!s_pos) begin
        res_r[ch_r] <= 8'd0;
      end else if (t_pos) begin
        if (f_sat) begin
          res_r[ch_r] <= 8'hFF;
        end
      end else begin
        res_r[ch_r] <= nonorm_val;
      end
    end
    if ((state_r == S_F_DIV) && div_done) begin
      res_r[ch_r] <= quot_r[7:0];
    end

    // result register
    if ((state_r == S_OUT) && out_free) begin
      out_data_r.red_out   <= res_r[0];
      out_data_r.green_out <= res_r[1];
      out_data_r.blue_out  <= res_r[2];
      out_data_r.alpha_out <= res_r[3];
    end
  end

endmodule

### verif/tb_bicubic_image_resampler.sv
module tb_bicubic_image_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_DEPTH = bir_pkg::MAX_SRC_WIDTH * bir_pkg::MAX_SRC_HEIGHT;

  // predicts resampled pixels and holds the ones still owed by the block
  class pixel_scoreboard;
    logic [31:0] pixel_mem [PIX_DEPTH];
    logic [8:0] src_w = 16, src_h = 16, dst_w = 16, dst_h = 16;
    logic kernel = bir_pkg::KERNEL_MITCHELL;
    bir_pkg::bir_out_t owed [$];
    int mismatches = 0;
    int results = 0;

    function void set_reg(logic [bir_pkg::CFG_IDX_W-1:0] idx,
                          logic [bir_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bir_pkg::REG_SRC_WIDTH: src_w = val;
        bir_pkg::REG_SRC_HEIGHT: src_h = val;
        bir_pkg::REG_DST_WIDTH: dst_w = val;
        bir_pkg::REG_DST_HEIGHT: dst_h = val;
        bir_pkg::REG_KERNEL_SEL: kernel = val[0];
        default: ;
      endcase
    endfunction

    function longint eff_size(logic [8:0] v, longint lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function longint div_round(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    // kernel value at distance a/256, scaled to signed q2.f
    function longint tap_weight(longint a);
      longint unit, n;
      unit = longint'(1) << 24;
      if (kernel == bir_pkg::KERNEL_HERMITE) begin
        if (a >= 256) return 0;
        n = 2 * a * a * a - 3 * 256 * a * a + unit;
        return div_round(n << bir_pkg::WEIGHT_FRAC_BITS, unit);
      end
      if (a < 256) n = 16 * unit + a * a * (21 * a - 36 * 256);
      else if (a < 512) n = 32 * unit + a * (-60 * 65536 + a * (36 * 256 - 7 * a));
      else return 0;
      return div_round(n << bir_pkg::WEIGHT_FRAC_BITS, 18 * unit);
    endfunction

    // source position of one axis and its four tap weights
    function void axis_taps(logic [7:0] d, longint sz, longint dsz,
                            output longint base, output longint w [4]);
      longint p, t, a;
      p = ((2 * longint'(d) + 1) * sz * 256) / (2 * dsz);
      t = p & 255;
      base = p >>> 8;
      for (int i = 0; i < 4; i++) begin
        a = 256 * (i - 1) - t;
        if (a < 0) a = -a;
        w[i] = tap_weight(a);
      end
    endfunction

    function logic [7:0] normalize(longint s, longint tot);
      longint v;
      if (s <= 0) return 0;
      if (tot > 0) v = (2 * s + tot) / (2 * tot);
      else v = (s + (longint'(1) << (2 * bir_pkg::WEIGHT_FRAC_BITS - 1))) >>>
               (2 * bir_pkg::WEIGHT_FRAC_BITS);
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function bir_pkg::bir_out_t resample(logic [7:0] dx, logic [7:0] dy);
      longint sw, sh, wx [4], wy [4], bx, by, xx, yy, w, tot;
      longint sums [4];
      logic [31:0] px;
      bir_pkg::bir_out_t r;
      sw = eff_size(src_w, bir_pkg::MAX_SRC_WIDTH);
      sh = eff_size(src_h, bir_pkg::MAX_SRC_HEIGHT);
      axis_taps(dx, sw, eff_size(dst_w, bir_pkg::MAX_DST_SIZE), bx, wx);
      axis_taps(dy, sh, eff_size(dst_h, bir_pkg::MAX_DST_SIZE), by, wy);
      tot = 0;
      for (int c = 0; c < 4; c++) sums[c] = 0;
      for (int j = 0; j < 4; j++) begin
        yy = by + j - 1;
        if (yy < 0) yy = 0;
        if (yy >= sh) yy = sh - 1;
        for (int i = 0; i < 4; i++) begin
          xx = bx + i - 1;
          if (xx < 0) xx = 0;
          if (xx >= sw) xx = sw - 1;
          w = wx[i] * wy[j];
          px = pixel_mem[yy * bir_pkg::MAX_SRC_WIDTH + xx];
          for (int c = 0; c < 4; c++) sums[c] += longint'(px[8*c +: 8]) * w;
          tot += w;
        end
      end
      r.red_out = normalize(sums[0], tot);
      r.green_out = normalize(sums[1], tot);
      r.blue_out = normalize(sums[2], tot);
      r.alpha_out = normalize(sums[3], tot);
      return r;
    endfunction

    function void note_input(bir_pkg::bir_in_t it);
      if (it.opcode == bir_pkg::OP_WRITE)
        pixel_mem[int'(it.src_y) * bir_pkg::MAX_SRC_WIDTH + int'(it.src_x)] =
          {it.alpha_in, it.blue_in, it.green_in, it.red_in};
      else
        owed.push_back(resample(it.dst_x, it.dst_y));
    endfunction

    function void check_result(bir_pkg::bir_out_t got);
      bir_pkg::bir_out_t exp_px;
      results++;
      if (owed.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %h", got);
        mismatches++;
        return;
      end
      exp_px = owed.pop_front();
      if (got.red_out !== exp_px.red_out || got.green_out !== exp_px.green_out ||
          got.blue_out !== exp_px.blue_out || got.alpha_out !== exp_px.alpha_out) begin
        if (mismatches < 10)
          $display("pixel mismatch at %0t: expected rgba %h, got %h", $realtime, exp_px, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  bir_pkg::bir_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  bir_pkg::bir_out_t out_data;
  logic cfg_we = 0;
  logic [bir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bir_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  bit written [PIX_DEPTH];
  int in_idle_pct = 0, out_idle_pct = 0;
  int n_requests = 0, n_writes = 0;
  int cur_sw = 16, cur_sh = 16, cur_dw = 16, cur_dh = 16;

  bicubic_image_resampler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // one input transfer, with random gaps ahead of it
  task automatic send(bir_pkg::bir_in_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (it.opcode == bir_pkg::OP_WRITE) begin
      written[int'(it.src_y) * bir_pkg::MAX_SRC_WIDTH + int'(it.src_x)] = 1;
      n_writes++;
    end else begin
      n_requests++;
    end
  endtask

  task automatic write_pixel(int x, int y, logic [31:0] rgba);
    bir_pkg::bir_in_t it;
    it = {$urandom, $urandom, 1'b0};
    it.opcode = bir_pkg::OP_WRITE;
    it.src_x = 8'(x);
    it.src_y = 8'(y);
    {it.alpha_in, it.blue_in, it.green_in, it.red_in} = rgba;
    send(it);
  endtask

  task automatic request(int x, int y);
    bir_pkg::bir_in_t it;
    it = {$urandom, $urandom, 1'b0};
    it.opcode = bir_pkg::OP_REQUEST;
    it.dst_x = 8'(x);
    it.dst_y = 8'(y);
    send(it);
  endtask

  // let the block drain before touching registers
  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [bir_pkg::CFG_IDX_W-1:0] idx,
                           logic [bir_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  // every pixel that a clamped read can touch must be written first
  task automatic fill_region();
    for (int y = 0; y < cur_sh; y++)
      for (int x = 0; x < cur_sw; x++)
        if (!written[y * bir_pkg::MAX_SRC_WIDTH + x]) write_pixel(x, y, $urandom);
  endtask

  task automatic set_phase(int sw, int sh, int dw, int dh, int k);
    wait_idle();
    write_reg(bir_pkg::REG_SRC_WIDTH, 9'(sw));
    write_reg(bir_pkg::REG_SRC_HEIGHT, 9'(sh));
    write_reg(bir_pkg::REG_DST_WIDTH, 9'(dw));
    write_reg(bir_pkg::REG_DST_HEIGHT, 9'(dh));
    write_reg(bir_pkg::REG_KERNEL_SEL,
              (k != 0) ? 9'(bir_pkg::KERNEL_HERMITE) : 9'(bir_pkg::KERNEL_MITCHELL));
    cur_sw = int'(sb.eff_size(9'(sw), bir_pkg::MAX_SRC_WIDTH));
    cur_sh = int'(sb.eff_size(9'(sh), bir_pkg::MAX_SRC_HEIGHT));
    cur_dw = int'(sb.eff_size(9'(dw), bir_pkg::MAX_DST_SIZE));
    cur_dh = int'(sb.eff_size(9'(dh), bir_pkg::MAX_DST_SIZE));
  endtask

  // mostly in-range requests, some beyond the target size, writes in and out of the image
  task automatic random_items(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(99) < 85)
          request($urandom_range(cur_dw - 1), $urandom_range(cur_dh - 1));
        else
          request($urandom_range(255), $urandom_range(255));
      end else if ($urandom_range(1)) begin
        write_pixel($urandom_range(cur_sw - 1), $urandom_range(cur_sh - 1), $urandom);
      end else begin
        write_pixel($urandom_range(255), $urandom_range(255), $urandom);
      end
    end
  endtask

  initial begin
    int sw, sh, dw, dh;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset sizes, extreme bytes and target corners
    in_idle_pct = 31;
    out_idle_pct = 77;
    write_pixel(0, 0, 32'hffff_ffff);
    write_pixel(15, 15, 32'h0000_0000);
    write_pixel(255, 255, 32'hffff_ffff);
    write_pixel(255, 0, 32'h00ff_00ff);
    fill_region();
    request(0, 0);
    request(15, 15);
    request(255, 255);
    request(16, 16);
    request(0, 15);
    request(15, 0);
    request(128, 7);
    random_items(80);

    // fixed phases cover zero and oversized sizes and both kernels, then random ones
    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: begin sw = 5; sh = 7; dw = 13; dh = 3; end
        1: begin sw = 0; sh = 0; dw = 0; dh = 0; end
        2: begin sw = 511; sh = 1; dw = 256; dh = 2; end
        3: begin sw = 1; sh = 300; dw = 1; dh = 511; end
        4: begin sw = 256; sh = 1; dw = 255; dh = 1; end
        5: begin sw = 1; sh = 256; dw = 40; dh = 256; end
        default: begin
          sw = $urandom_range(1, 20);
          sh = $urandom_range(1, 20);
          dw = $urandom_range(1, 40);
          dh = $urandom_range(1, 40);
        end
      endcase
      set_phase(sw, sh, dw, dh, ph % 2);
      if (ph >= 8) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else if (ph >= 4) begin
        in_idle_pct = 77;
        out_idle_pct = 31;
      end
      fill_region();
      request(0, 0);
      request(cur_dw - 1, cur_dh - 1);
      random_items(25);
    end

    wait_idle();
    sb.mismatches += sb.owed.size();
    $display("covered %0d pixel writes and %0d resample requests over 14 size/kernel settings",
             n_writes, n_requests);
    $display("%0d results checked, %0d mismatches", sb.results, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
